>>> rtl/csvf_pkg.sv
// Shared constants of the cascaded state-variable highpass filter: register map and reset values.
package csvf_pkg;

    // Coefficient registers are unsigned Q1.30 values held in 31 bits.
    localparam int COEF_BITS = 31;

    // Section count register width.
    localparam int CNT_BITS = 3;

    // Configuration port geometry.
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    // Register indexes (byte address is four times the index).
    localparam logic [REG_IDX_BITS-1:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A0     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A1     = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A2     = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_DAMPING_K   = 3'd4;

    // Reset values: one section, cutoff and damping of a Butterworth section.
    localparam logic [CNT_BITS-1:0]  RST_STAGE_COUNT = 3'd1;
    localparam logic [COEF_BITS-1:0] RST_COEF_A0     = 31'd1057957820;
    localparam logic [COEF_BITS-1:0] RST_COEF_A1     = 31'd11078870;
    localparam logic [COEF_BITS-1:0] RST_COEF_A2     = 31'd116018;
    localparam logic [COEF_BITS-1:0] RST_DAMPING_K   = 31'd1518500250;

    // Fraction bits of a Q1.30 coefficient; a product is shifted right by this amount.
    localparam int Q30_SHIFT = 30;

endpackage

>>> rtl/cascaded_svf_highpass_core.sv
// Cascaded trapezoidal state-variable highpass filter: top level with sequencer and state memory.
//
// Usage: audio samples enter on the s_axis channel (one signed sample per transaction) and
// the filtered sample leaves on the m_axis channel, exactly one result per input. The
// coefficients a0, a1, a2, the damping k and the number of active sections are written over
// the APB-style port while the block is idle; they take effect with the next sample and do
// not disturb the integrator states.
// Sequencing: with N active sections (the register value, limited to MAX_STAGES), a sample is
// processed section by section and its result then moves to the m_axis output register.
// One multiplier is shared by all sections; each section takes a load state, five products
// in sequence and a write-back state.
// A new sample is taken only once the previous one has reached the output register, so the
// block does not accept a sample while it is still processing the last one.
// Reset clears the control state, restores the register reset values, and marks every
// section's integrators as zero through per-row valid bits; no clearing pass is needed.
// When the receiver stalls, the finished sample waits in the output register while the block
// still takes and processes the next sample; that one then waits until the output frees up.
module cascaded_svf_highpass_core
    import csvf_pkg::*;
#(
    parameter int MAX_STAGES  = 4,
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input sample stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // [SAMPLE_BITS-1:0] sample_in
    // Output sample stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // [SAMPLE_BITS-1:0] sample_out
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready
);

    // Widths of the datapath. Working values keep STATE_BITS-1 fraction bits; the raw product holds Q30_SHIFT more.
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ROW_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_W   = $clog2(MAX_STAGES + 1);
    localparam int V2_W    = STATE_BITS + 1;            // x - s1
    localparam int M_W     = STATE_BITS + 3;            // widest multiplier operand (v0)
    localparam int P_W     = M_W + COEF_BITS + 1;       // product with a sign bit on the coef
    localparam int W       = P_W - Q30_SHIFT;           // working sums before saturation
    localparam int X_W     = (W > SAMPLE_BITS + 1) ? W : SAMPLE_BITS + 1;
    localparam int SX_W    = SAMPLE_BITS + 1;
    localparam int ST1_W   = STATE_BITS + 1;
    localparam int SHIFT_D = STATE_BITS - SAMPLE_BITS;
    localparam int NEG_D   = -SHIFT_D;

    localparam logic signed [X_W-1:0] ST_MAX  = X_W'({(STATE_BITS-1){1'b1}});
    localparam logic signed [X_W-1:0] ST_MIN  = ~ST_MAX;
    localparam logic signed [X_W-1:0] SM_MAX  = X_W'({(SAMPLE_BITS-1){1'b1}});
    localparam logic signed [X_W-1:0] SM_MIN  = ~SM_MAX;
    localparam logic signed [P_W-1:0] RND_Q30 = P_W'(1) <<< (Q30_SHIFT - 1);

    // Sequencer states. The multiply states are named after the product that the shared
    // multiplier forms in that cycle.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_M_S0A0,
        ST_M_V2A1,
        ST_M_S0A1,
        ST_M_V2A2,
        ST_M_V0K,
        ST_WRITE,
        ST_DONE
    } t_state;

    function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [X_W-1:0] v);
        logic signed [X_W-1:0] t;
        begin
            if (v > ST_MAX) begin
                t = ST_MAX;
            end else if (v < ST_MIN) begin
                t = ST_MIN;
            end else begin
                t = v;
            end
            return t[STATE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [X_W-1:0] v);
        logic signed [X_W-1:0] t;
        begin
            if (v > SM_MAX) begin
                t = SM_MAX;
            end else if (v < SM_MIN) begin
                t = SM_MIN;
            end else begin
                t = v;
            end
            return t[SAMPLE_BITS-1:0];
        end
    endfunction

    // Round a product with a Q1.30 coefficient to nearest, ties toward plus infinity.
    function automatic logic signed [W-1:0] rnd_q30(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] t;
        begin
            t = p + RND_Q30;
            return $signed(t[P_W-1:Q30_SHIFT]);
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------------------
    logic [CNT_BITS-1:0]     r_stage_count;
    logic [COEF_BITS-1:0]    r_coef_a0;
    logic [COEF_BITS-1:0]    r_coef_a1;
    logic [COEF_BITS-1:0]    r_coef_a2;
    logic [COEF_BITS-1:0]    r_damping_k;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count <= RST_STAGE_COUNT;
            r_coef_a0     <= RST_COEF_A0;
            r_coef_a1     <= RST_COEF_A1;
            r_coef_a2     <= RST_COEF_A2;
            r_damping_k   <= RST_DAMPING_K;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_STAGE_COUNT: r_stage_count <= pwdata[CNT_BITS-1:0];
                REG_COEF_A0:     r_coef_a0     <= pwdata[COEF_BITS-1:0];
                REG_COEF_A1:     r_coef_a1     <= pwdata[COEF_BITS-1:0];
                REG_COEF_A2:     r_coef_a2     <= pwdata[COEF_BITS-1:0];
                REG_DAMPING_K:   r_damping_k   <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STAGE_COUNT: prdata = APB_DATA_BITS'(r_stage_count);
            REG_COEF_A0:     prdata = APB_DATA_BITS'(r_coef_a0);
            REG_COEF_A1:     prdata = APB_DATA_BITS'(r_coef_a1);
            REG_COEF_A2:     prdata = APB_DATA_BITS'(r_coef_a2);
            REG_DAMPING_K:   prdata = APB_DATA_BITS'(r_damping_k);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------------------
    // Registers of the sequencer and the datapath
    // ------------------------------------------------------------------------------------
    t_state                         r_state;
    logic [CNT_W-1:0]               r_n;       // active sections of the current sample
    logic [ROW_W-1:0]               r_sec;     // section being processed
    logic signed [STATE_BITS-1:0]   r_x;       // running section input / output
    logic signed [STATE_BITS-1:0]   r_s0;
    logic signed [STATE_BITS-1:0]   r_s1;
    logic signed [V2_W-1:0]         r_v2;
    logic signed [W-1:0]            r_v0;
    logic signed [W-1:0]            r_v1;
    logic signed [P_W-1:0]          r_prod;
    logic                           r_out_valid;
    logic [TDATA_W-1:0]             r_out_data;

    // ------------------------------------------------------------------------------------
    // Integrator memory: one row per section holding {s1, s0}. A row that was never
    // written since reset reads as zero through its valid bit.
    // ------------------------------------------------------------------------------------
    logic [2*STATE_BITS-1:0]  mem_integ [MAX_STAGES];
    logic [MAX_STAGES-1:0]    r_row_valid;
    logic [2*STATE_BITS-1:0]  r_rd_row;
    logic                     r_rd_valid;
    logic                     rd_en;
    logic [ROW_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [2*STATE_BITS-1:0]  wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_integ[r_sec] <= wr_data;
        end
        if (rd_en) begin
            r_rd_row <= mem_integ[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[r_sec] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_valid <= r_row_valid[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Format conversion between the sample and the working format
    // ------------------------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0]  in_sample;
    logic signed [STATE_BITS-1:0]   x_in;
    logic signed [SAMPLE_BITS-1:0]  out_sample;

    assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];

    if (SHIFT_D >= 0) begin : g_in_widen
        assign x_in = STATE_BITS'(in_sample) <<< SHIFT_D;
    end else begin : g_in_round
        logic signed [SX_W-1:0] in_rnd;
        assign in_rnd = SX_W'(in_sample) + (SX_W'(1) <<< (NEG_D - 1));
        assign x_in   = sat_state(X_W'(in_rnd >>> NEG_D));
    end

    if (SHIFT_D > 0) begin : g_out_round
        logic signed [ST1_W-1:0] out_rnd;
        assign out_rnd    = ST1_W'(r_x) + (ST1_W'(1) <<< (SHIFT_D - 1));
        assign out_sample = sat_sample(X_W'(out_rnd >>> SHIFT_D));
    end else begin : g_out_widen
        assign out_sample = sat_sample(X_W'(r_x) <<< NEG_D);
    end

    // ------------------------------------------------------------------------------------
    // Combinational control and the shared multiplier's operand selection
    // ------------------------------------------------------------------------------------
    logic                           in_accept;
    logic [CNT_W-1:0]               stage_lim;
    logic                           last_sec;
    logic signed [STATE_BITS-1:0]   rd_s0;
    logic signed [STATE_BITS-1:0]   rd_s1;
    logic signed [M_W-1:0]          mul_op;
    logic [COEF_BITS-1:0]           mul_coef;
    logic signed [W-1:0]            prod_rnd;
    logic signed [STATE_BITS-1:0]   s0_new;
    logic signed [STATE_BITS-1:0]   s1_new;
    logic signed [STATE_BITS-1:0]   y_sec;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Section count saturates at the number of rows the memory holds.
    assign stage_lim = ({1'b0, r_stage_count} > 4'(MAX_STAGES)) ? CNT_W'(MAX_STAGES)
                                                                  : CNT_W'(r_stage_count);
    assign last_sec  = (CNT_W'(r_sec) + CNT_W'(1)) >= r_n;

    assign rd_s0 = r_rd_valid ? $signed(r_rd_row[STATE_BITS-1:0]) : '0;
    assign rd_s1 = r_rd_valid ? $signed(r_rd_row[2*STATE_BITS-1:STATE_BITS]) : '0;

    always_comb begin
        unique case (r_state)
            ST_M_S0A0: begin
                mul_op   = M_W'(r_s0);
                mul_coef = r_coef_a0;
            end
            ST_M_V2A1: begin
                mul_op   = M_W'(r_v2);
                mul_coef = r_coef_a1;
            end
            ST_M_S0A1: begin
                mul_op   = M_W'(r_s0);
                mul_coef = r_coef_a1;
            end
            ST_M_V2A2: begin
                mul_op   = M_W'(r_v2);
                mul_coef = r_coef_a2;
            end
            ST_M_V0K: begin
                mul_op   = M_W'(r_v0);
                mul_coef = r_damping_k;
            end
            default: begin
                mul_op   = '0;
                mul_coef = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_op * $signed({1'b0, mul_coef});
    end

    assign prod_rnd = rnd_q30(r_prod);

    // Write-back values and the section output, formed in the write-back cycle when the
    // product register holds k*v0.
    assign s0_new = sat_state(X_W'((r_v0 <<< 1) - W'(r_s0)));
    assign s1_new = sat_state(X_W'((r_v1 <<< 1) - W'(r_s1)));
    assign y_sec  = sat_state(X_W'(W'(r_x) - prod_rnd - r_v1));

    // The next section's row is read in the same cycle the current row is written; the
    // two addresses always differ, and a following sample reads row zero only after all
    // writes of this one have landed, so no forwarding is needed.
    assign wr_en   = (r_state == ST_WRITE);
    assign wr_data = {s1_new, s0_new};
    assign rd_en   = (in_accept && (stage_lim != '0)) || ((r_state == ST_WRITE) && !last_sec);
    assign rd_addr = in_accept ? '0 : r_sec + ROW_W'(1);

    // ------------------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_sec       <= '0;
        end else begin
            // While a finished sample waits in ST_DONE, that arm alone drives the valid flag.
            if (m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_x   <= x_in;
                        r_n   <= stage_lim;
                        r_sec <= '0;
                        r_state <= (stage_lim == '0) ? ST_DONE : ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_s0    <= rd_s0;
                    r_s1    <= rd_s1;
                    r_v2    <= V2_W'(r_x) - V2_W'(rd_s1);
                    r_state <= ST_M_S0A0;
                end
                ST_M_S0A0: begin
                    r_state <= ST_M_V2A1;
                end
                ST_M_V2A1: begin
                    r_v0    <= prod_rnd;
                    r_state <= ST_M_S0A1;
                end
                ST_M_S0A1: begin
                    r_v0    <= r_v0 + prod_rnd;
                    r_state <= ST_M_V2A2;
                end
                ST_M_V2A2: begin
                    r_v1    <= W'(r_s1) + prod_rnd;
                    r_state <= ST_M_V0K;
                end
                ST_M_V0K: begin
                    r_v1    <= r_v1 + prod_rnd;
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_x <= y_sec;
                    if (last_sec) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_sec   <= r_sec + ROW_W'(1);
                        r_state <= ST_LOAD;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= TDATA_W'($unsigned(out_sample));
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> test/cascaded_svf_highpass_core_tb.sv
// Self-checking testbench for the cascaded state-variable highpass core, driven over its stream and APB ports.
module cascaded_svf_highpass_core_tb;
    import csvf_pkg::*;

    localparam int MAX_STAGES  = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int STATE_BITS  = 32;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

    // Rescaling between the Q1.23 sample format and the Q1.31 working format.
    localparam int FRAC_SHIFT = (STATE_BITS - 1) - (SAMPLE_BITS - 1);

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;
    localparam logic [COEF_BITS-1:0]          COEF_MAX = 31'h7FFFFFFF;

    // Addresses past the last register; writes there must be ignored.
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

    // Idle time after the last expected sample; the worst case is four sections.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 206;

    typedef enum {SEG_NOISE, SEG_HOLD, SEG_NYQUIST, SEG_QUIET, SEG_RAIL} t_segment_kind;
    typedef enum {CFG_DESIGNED, CFG_RAW, CFG_NO_DAMPING, CFG_MAX_DAMPING} t_coef_plan;

    // Clock, reset and every block input start at known values.
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [TDATA_BITS-1:0]     s_axis_tdata = '0;   // [23:0] sample_in
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0]     m_axis_tdata;        // [23:0] sample_out
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // Predictor copy of the configuration and of the integrators of every section.
    logic [CNT_BITS-1:0]          cfg_stages;
    logic [COEF_BITS-1:0]         cfg_a0;
    logic [COEF_BITS-1:0]         cfg_a1;
    logic [COEF_BITS-1:0]         cfg_a2;
    logic [COEF_BITS-1:0]         cfg_damping;
    logic signed [STATE_BITS-1:0] integ_s0 [MAX_STAGES];
    logic signed [STATE_BITS-1:0] integ_s1 [MAX_STAGES];

    // Filtered samples still owed by the block, oldest first.
    logic [SAMPLE_BITS-1:0] pending_outputs [$];
    int                     mismatch_count = 0;

    // When set, neither side inserts gaps, so the block runs back to back.
    bit steady_flow = 1'b0;
    int rx_stall_left = 0;

    cascaded_svf_highpass_core #(
        .MAX_STAGES  (MAX_STAGES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of one filter section.
    // ------------------------------------------------------------------

    // Clamps a value to the signed range of the given width.
    function automatic logic signed [63:0] clamp_signed(input logic signed [63:0] v,
                                                        input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Product with an unsigned Q1.30 coefficient, rounded to nearest with ties
    // going up. The arithmetic shift of a signed value is a floor division.
    function automatic logic signed [63:0] q30_product(input logic signed [63:0] v,
                                                       input logic [COEF_BITS-1:0] c);
        logic signed [127:0] wide_v;
        logic signed [127:0] wide_c;
        logic signed [127:0] prod;
        wide_v = 128'(v);
        wide_c = $signed({97'd0, c});
        prod = wide_v * wide_c + (128'sd1 <<< (Q30_SHIFT - 1));
        return 64'(prod >>> Q30_SHIFT);
    endfunction

    // One trapezoidal highpass section: updates its two integrators and returns
    // the section output, clamped to the working range.
    function automatic logic signed [63:0] highpass_section(input int j,
                                                            input logic signed [63:0] x);
        logic signed [63:0] s0;
        logic signed [63:0] s1;
        logic signed [63:0] v0;
        logic signed [63:0] v1;
        logic signed [63:0] v2;
        s0 = 64'(integ_s0[j]);
        s1 = 64'(integ_s1[j]);
        v2 = x - s1;
        v0 = q30_product(s0, cfg_a0) + q30_product(v2, cfg_a1);
        v1 = s1 + q30_product(s0, cfg_a1) + q30_product(v2, cfg_a2);
        integ_s0[j] = STATE_BITS'(clamp_signed(2 * v0 - s0, STATE_BITS));
        integ_s1[j] = STATE_BITS'(clamp_signed(2 * v1 - s1, STATE_BITS));
        return clamp_signed(x - q30_product(v0, cfg_damping) - v1, STATE_BITS);
    endfunction

    // Runs one sample through the active sections and returns the expected output.
    // Stage counts above the number of built sections saturate; sections beyond
    // the active count keep their integrators untouched.
    function automatic logic [SAMPLE_BITS-1:0] filter_sample(input logic [SAMPLE_BITS-1:0] raw);
        logic signed [63:0] acc;
        int                 active;
        acc = 64'($signed(raw));
        acc = acc <<< FRAC_SHIFT;
        active = (cfg_stages > MAX_STAGES) ? MAX_STAGES : int'(cfg_stages);
        for (int j = 0; j < active; j++)
            acc = highpass_section(j, acc);
        acc = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        acc = clamp_signed(acc, SAMPLE_BITS);
        return acc[SAMPLE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Idle-time shaping: mostly no gap or a short one, now and then a long one.
    // ------------------------------------------------------------------

    function automatic int sender_gap();
        int roll;
        if (steady_flow) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int receiver_stall();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // The receiver drops tready for random stretches unless steady flow is on.
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 7) == 0)
                rx_stall_left <= receiver_stall();
        end
    end

    // Every output transaction is matched against the oldest expected sample.
    always @(posedge i_clk) begin
        logic [SAMPLE_BITS-1:0] want;
        logic [SAMPLE_BITS-1:0] got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[SAMPLE_BITS-1:0];
            if (pending_outputs.size() == 0) begin
                $error("sample_out: no sample expected, got %0d", $signed(got));
                mismatch_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (got !== want) begin
                    $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Bus tasks. Each one starts and ends on a rising clock edge.
    // ------------------------------------------------------------------

    // Presents one sample after a random gap and waits for its transaction.
    // tvalid is lowered only when a gap follows, so it never toggles twice
    // within one time step.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_outputs.push_back(filter_sample(smp));
    endtask

    // Lets the pipeline empty out so that registers can be changed safely.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then a return to idle. The predictor
    // copy follows the same masking that the register widths impose.
    task automatic write_register(input logic [REG_IDX_BITS-1:0] idx,
                                  input logic [APB_DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_STAGE_COUNT: cfg_stages  = value[CNT_BITS-1:0];
            REG_COEF_A0:     cfg_a0      = value[COEF_BITS-1:0];
            REG_COEF_A1:     cfg_a1      = value[COEF_BITS-1:0];
            REG_COEF_A2:     cfg_a2      = value[COEF_BITS-1:0];
            REG_DAMPING_K:   cfg_damping = value[COEF_BITS-1:0];
            default: ;
        endcase
    endtask

    // Stage count with random junk in the unused upper bits of the data word.
    task automatic write_stage_count(input logic [CNT_BITS-1:0] stages);
        logic [APB_DATA_BITS-1:0] junk;
        junk = $urandom;
        write_register(REG_STAGE_COUNT, {junk[APB_DATA_BITS-1:CNT_BITS], stages});
    endtask

    task automatic write_coefficients(input logic [APB_DATA_BITS-1:0] a0,
                                      input logic [APB_DATA_BITS-1:0] a1,
                                      input logic [APB_DATA_BITS-1:0] a2,
                                      input logic [APB_DATA_BITS-1:0] kd);
        write_register(REG_COEF_A0, a0);
        write_register(REG_COEF_A1, a1);
        write_register(REG_COEF_A2, a2);
        write_register(REG_DAMPING_K, kd);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset values: one Butterworth-like section, full-scale and near-zero inputs.
    task automatic test_reset_config();
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('0);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(SMP_MAX);
        wait_for_drain();
    endtask

    // Zero sections: the sample only goes to the working format and back.
    task automatic test_bypass();
        write_stage_count(3'd0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample('0);
        send_sample(-24'sd1);
        wait_for_drain();
    endtask

    // Stage counts above the built sections must behave like the maximum.
    task automatic test_stage_overrange();
        write_stage_count(3'd7);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(24'sd4096);
        wait_for_drain();
        write_stage_count(3'd5);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        wait_for_drain();
    endtask

    // All coefficients zero, then all at their ceiling so that integrators and
    // section outputs run into saturation on full-scale alternating input.
    task automatic test_coefficient_extremes();
        write_stage_count(3'd4);
        write_coefficients('0, '0, '0, '0);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(24'sd12345);
        wait_for_drain();
        write_coefficients('1, '1, '1, '1);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? SMP_MIN : SMP_MAX);
        wait_for_drain();
    endtask

    // Writes past the last register must leave the configuration alone.
    task automatic test_spare_registers();
        for (int a = REG_SPARE_FIRST; a <= REG_SPARE_LAST; a++)
            write_register(a[REG_IDX_BITS-1:0], $urandom);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        wait_for_drain();
    endtask

    // Loads a coefficient set. Designed sets follow a0 = 1/(1+g(g+k)), a1 = g*a0,
    // a2 = g*a1 for a random g; raw sets are arbitrary 32-bit words.
    task automatic configure_phase(input logic [CNT_BITS-1:0] stages, input t_coef_plan plan);
        longint unsigned g;
        longint unsigned kd;
        longint unsigned a0;
        longint unsigned a1;
        longint unsigned a2;
        write_stage_count(stages);
        if (plan == CFG_RAW) begin
            write_coefficients($urandom, $urandom, $urandom, $urandom);
        end else begin
            g = $urandom_range(1 << 20, 1 << 30);
            case (plan)
                CFG_NO_DAMPING:  kd = 0;
                CFG_MAX_DAMPING: kd = COEF_MAX;
                default:         kd = $urandom_range(1 << 28, COEF_MAX);
            endcase
            a0 = (64'd1 << 60) / ((64'd1 << 30) + ((g * (g + kd)) >> 30));
            a1 = (g * a0) >> 30;
            a2 = (g * a1) >> 30;
            // Spare upper bit of each word is set at random; the block must drop it.
            write_coefficients({1'($urandom), a0[30:0]}, {1'($urandom), a1[30:0]},
                               {1'($urandom), a2[30:0]}, {1'($urandom), kd[30:0]});
        end
    endtask

    // Signal-like segments of 4 to 40 samples: wideband noise, steps, full-rate
    // alternation, quiet passages and rail-to-rail jumps.
    task automatic run_random_phase(input int count);
        t_segment_kind          kind;
        logic [SAMPLE_BITS-1:0] level;
        logic [SAMPLE_BITS-1:0] smp;
        int                     seg_len;
        int                     sent;
        sent = 0;
        while (sent < count) begin
            kind = t_segment_kind'($urandom_range(0, 4));
            seg_len = $urandom_range(4, 40);
            level = SAMPLE_BITS'($urandom);
            for (int i = 0; i < seg_len && sent < count; i++) begin
                case (kind)
                    SEG_NOISE:   smp = SAMPLE_BITS'($urandom);
                    SEG_HOLD:    smp = level;
                    SEG_NYQUIST: smp = i[0] ? ~level : level;
                    SEG_QUIET:   smp = SAMPLE_BITS'($urandom_range(0, 511) - 256);
                    default:     smp = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
                endcase
                send_sample(smp);
                sent++;
            end
        end
        wait_for_drain();
    endtask

    // Phases walk through stage counts zero to five and seven, including the overrange
    // codes, with both designed and arbitrary coefficient sets. Two phases run
    // without any idling so the block is exercised back to back.
    task automatic test_random_phases();
        logic [CNT_BITS-1:0] phase_stages [RANDOM_PHASES];
        t_coef_plan          phase_plan [RANDOM_PHASES];
        phase_stages = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd1, 3'd4, 3'd5};
        phase_plan = '{CFG_DESIGNED, CFG_DESIGNED, CFG_RAW, CFG_NO_DAMPING,
                       CFG_DESIGNED, CFG_MAX_DAMPING, CFG_DESIGNED, CFG_RAW};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            configure_phase(phase_stages[p], phase_plan[p]);
            steady_flow = (p == 1 || p == 4);
            run_random_phase(ITEMS_PER_PHASE);
            steady_flow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial begin
        cfg_stages = RST_STAGE_COUNT;
        cfg_a0 = RST_COEF_A0;
        cfg_a1 = RST_COEF_A1;
        cfg_a2 = RST_COEF_A2;
        cfg_damping = RST_DAMPING_K;
        for (int j = 0; j < MAX_STAGES; j++) begin
            integ_s0[j] = '0;
            integ_s1[j] = '0;
        end

        // Synchronous reset held at the start, then released.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_bypass();
        test_stage_overrange();
        test_coefficient_extremes();
        test_spare_registers();
        test_random_phases();

        // Anything arriving after the last expected sample is a failure too.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Safety net: several times the slowest legal run.
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/csvf_pkg.sv
rtl/cascaded_svf_highpass_core.sv
test/cascaded_svf_highpass_core_tb.sv
